/* rtl/sdre_pkg.sv */
// shared constants and types of the signed radix digit encoder
package sdre_pkg;

    // alphabet table geometry
    localparam int MAX_RADIX  = 64;
    localparam int AlphAddrW  = $clog2(MAX_RADIX);
    localparam int RadixW     = AlphAddrW + 1;
    localparam int CharW      = 8;

    // digit stack geometry
    localparam int MAX_DIGITS = 32;
    localparam int StackAddrW = $clog2(MAX_DIGITS);
    localparam int CountW     = StackAddrW + 1;
    localparam int DigitW     = AlphAddrW;

    // value width
    localparam int ValueW     = 32;
    localparam int StepW      = $clog2(ValueW);

    // request kinds
    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_CONVERT = 1'b1;

    // character codes
    localparam logic [CharW-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CharW-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CharW-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CharW-1:0] CHAR_LO    = 8'd32;
    localparam logic [CharW-1:0] CHAR_HI    = 8'd126;

    // divider command
    typedef struct packed {
        logic              start;
        logic [ValueW-1:0] dividend;
        logic [RadixW-1:0] divisor;
    } div_cmd_t;

    // divider status
    typedef struct packed {
        logic              done;
        logic [ValueW-1:0] quotient;
        logic [DigitW-1:0] remainder;
    } div_status_t;

endpackage

/* rtl/sdre_if.sv */
// request and result channel interfaces

// request channel: load a symbol or convert a value
interface sdre_req_if
    import sdre_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic [AlphAddrW-1:0]     symbol_index;
    logic [CharW-1:0]         symbol_byte;
    logic signed [ValueW-1:0] number_value;

    modport source (
        output valid, req_type, symbol_index, symbol_byte, number_value,
        input  ready
    );
    modport sink (
        input  valid, req_type, symbol_index, symbol_byte, number_value,
        output ready
    );
endinterface

// result channel: one character per transfer
interface sdre_res_if
    import sdre_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CharW-1:0] out_char;
    logic             run_last;

    modport source (
        output valid, out_char, run_last,
        input  ready
    );
    modport sink (
        input  valid, out_char, run_last,
        output ready
    );
endinterface

/* rtl/sdre_alpha_ram.sv */
// alphabet table memory with per-entry valid bits cleared at reset
module sdre_alpha_ram
    import sdre_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 we,
    input  logic [AlphAddrW-1:0] waddr,
    input  logic [CharW-1:0]     wdata,
    input  logic                 re,
    input  logic [AlphAddrW-1:0] raddr,
    output logic [CharW-1:0]     rdata
);

    logic [CharW-1:0]     mem [MAX_RADIX];
    logic [MAX_RADIX-1:0] valid_reg;
    logic [CharW-1:0]     data_reg;
    logic                 hit_reg;

    // storage array
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            data_reg <= mem[raddr];
        end
    end

    // valid bits, an entry never written reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                hit_reg <= valid_reg[raddr];
            end
        end
    end

    assign rdata = hit_reg ? data_reg : CHAR_NUL;

endmodule

/* rtl/sdre_stack_ram.sv */
// digit stack memory, one write and one registered read port
module sdre_stack_ram
    import sdre_pkg::*;
(
    input  logic                  clk,
    input  logic                  we,
    input  logic [StackAddrW-1:0] waddr,
    input  logic [DigitW-1:0]     wdata,
    input  logic                  re,
    input  logic [StackAddrW-1:0] raddr,
    output logic [DigitW-1:0]     rdata
);

    logic [DigitW-1:0] mem [MAX_DIGITS];
    logic [DigitW-1:0] data_reg;

    // storage array with registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            data_reg <= mem[raddr];
        end
    end

    assign rdata = data_reg;

endmodule

/* rtl/sdre_divider.sv */
// restoring divider, one quotient bit per cycle
module sdre_divider
    import sdre_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  div_cmd_t    cmd,
    output div_status_t status
);

    logic              busy_reg;
    logic              done_reg;
    logic [StepW-1:0]  step_reg;
    logic [ValueW-1:0] quo_reg;
    logic [RadixW-1:0] rem_reg;
    logic [RadixW-1:0] div_reg;

    logic [RadixW:0]   trial;
    logic              fits;
    logic [RadixW:0]   diff;

    // one trial subtraction
    always_comb
    begin
        trial = {rem_reg, quo_reg[ValueW-1]};
        fits  = (trial >= {1'b0, div_reg});
        diff  = trial - {1'b0, div_reg};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == StepW'(ValueW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath, quotient shifts in where the dividend shifts out
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            quo_reg <= cmd.dividend;
            rem_reg <= '0;
            div_reg <= cmd.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[ValueW-2:0], fits};
            rem_reg <= fits ? diff[RadixW-1:0] : trial[RadixW-1:0];
        end
    end

    assign status.done      = done_reg;
    assign status.quotient  = quo_reg;
    assign status.remainder = rem_reg[DigitW-1:0];

endmodule

/* rtl/signed_radix_digit_encoder_unit.sv */
// top level: alphabet store, validation scan, digit generation and output
//
//  channel   dir   payload                                          request taken
//  request   in    req_type, symbol_index, symbol_byte, number_value valid & ready
//  result    out   out_char, run_last                                valid & ready
//
// a load request is taken in the idle state. a convert request scans the alphabet with
// a read and a check state per symbol (up to 64), then runs the divider once per digit
// and passes through a read, symbol and output state per emitted character.
// one request is in work at a time; a finished character waits in the output
// register, which lets the next request in while the sink stalls.
// reset clears the alphabet valid bits, so the table reads as empty.
module signed_radix_digit_encoder_unit
    import sdre_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    sdre_req_if.sink   request,
    sdre_res_if.source result
);

    // sequencer states
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_SCAN_RD   = 4'd1;
    localparam logic [3:0] S_SCAN_CHK  = 4'd2;
    localparam logic [3:0] S_SIGN      = 4'd3;
    localparam logic [3:0] S_DIV_START = 4'd4;
    localparam logic [3:0] S_DIV_WAIT  = 4'd5;
    localparam logic [3:0] S_POP_RD    = 4'd6;
    localparam logic [3:0] S_POP_SYM   = 4'd7;
    localparam logic [3:0] S_POP_OUT   = 4'd8;

    localparam int SeenW = 128;

    logic [3:0]           state_reg, state_next;
    logic                 neg_reg, neg_next;
    logic [ValueW-1:0]    mag_reg, mag_next;
    logic [AlphAddrW-1:0] scan_reg, scan_next;
    logic [RadixW-1:0]    radix_reg, radix_next;
    logic [SeenW-1:0]     seen_reg, seen_next;
    logic [CountW-1:0]    count_reg, count_next;
    logic                 oval_reg, oval_next;
    logic [CharW-1:0]     ochar_reg, ochar_next;
    logic                 olast_reg, olast_next;

    logic                 alph_we;
    logic                 alph_re;
    logic [AlphAddrW-1:0] alph_raddr;
    logic [CharW-1:0]     alph_rdata;
    logic                 stk_we;
    logic                 stk_re;
    logic [DigitW-1:0]    stk_rdata;
    logic [CountW-1:0]    count_dec;
    div_cmd_t             div_cmd;
    div_status_t          div_stat;

    logic                 slot_free;
    logic                 take;
    logic                 bad_char;
    logic [ValueW-1:0]    raw_value;

    // memories and divider
    sdre_alpha_ram u_alpha (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (alph_we),
        .waddr (request.symbol_index),
        .wdata (request.symbol_byte),
        .re    (alph_re),
        .raddr (alph_raddr),
        .rdata (alph_rdata)
    );

    sdre_stack_ram u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (count_reg[StackAddrW-1:0]),
        .wdata (div_stat.remainder),
        .re    (stk_re),
        .raddr (count_dec[StackAddrW-1:0]),
        .rdata (stk_rdata)
    );

    sdre_divider u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (div_cmd),
        .status (div_stat)
    );

    // handshake helpers
    assign slot_free = !oval_reg || result.ready;
    assign take      = request.valid && (state_reg == S_IDLE);
    assign count_dec = count_reg - 1'b1;
    assign raw_value = request.number_value;
    assign bad_char  = (alph_rdata < CHAR_LO) || (alph_rdata > CHAR_HI)
                    || (alph_rdata == CHAR_PLUS) || (alph_rdata == CHAR_MINUS)
                    || seen_reg[alph_rdata[6:0]];

    // memory and divider controls
    always_comb
    begin
        alph_we          = take && (request.req_type == REQ_LOAD);
        alph_re          = 1'b0;
        alph_raddr       = scan_reg;
        stk_we           = 1'b0;
        stk_re           = 1'b0;
        div_cmd.start    = (state_reg == S_DIV_START);
        div_cmd.dividend = mag_reg;
        div_cmd.divisor  = radix_reg;
        unique case (state_reg)
            S_SCAN_RD:
            begin
                alph_re = 1'b1;
            end
            S_POP_SYM:
            begin
                alph_re    = 1'b1;
                alph_raddr = stk_rdata;
            end
            S_DIV_WAIT:
            begin
                stk_we = div_stat.done;
            end
            S_POP_RD:
            begin
                stk_re = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        scan_next  = scan_reg;
        radix_next = radix_reg;
        seen_next  = seen_reg;
        count_next = count_reg;
        oval_next  = oval_reg && !result.ready;
        ochar_next = ochar_reg;
        olast_next = olast_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take && (request.req_type == REQ_CONVERT))
                begin
                    neg_next   = raw_value[ValueW-1];
                    mag_next   = raw_value[ValueW-1] ? (~raw_value + 1'b1) : raw_value;
                    scan_next  = '0;
                    seen_next  = '0;
                    count_next = '0;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (alph_rdata == CHAR_NUL)
                begin
                    radix_next = {1'b0, scan_reg};
                    state_next = (scan_reg < AlphAddrW'(2)) ? S_IDLE : S_SIGN;
                end
                else if (bad_char)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    seen_next[alph_rdata[6:0]] = 1'b1;
                    if (scan_reg == AlphAddrW'(MAX_RADIX - 1))
                    begin
                        radix_next = RadixW'(MAX_RADIX);
                        state_next = S_SIGN;
                    end
                    else
                    begin
                        scan_next  = scan_reg + 1'b1;
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_SIGN:
            begin
                if (!neg_reg)
                begin
                    state_next = S_DIV_START;
                end
                else if (slot_free)
                begin
                    oval_next  = 1'b1;
                    ochar_next = CHAR_MINUS;
                    olast_next = 1'b0;
                    state_next = S_DIV_START;
                end
            end
            S_DIV_START:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    count_next = count_reg + 1'b1;
                    mag_next   = div_stat.quotient;
                    state_next = (div_stat.quotient != '0) ? S_DIV_START : S_POP_RD;
                end
            end
            S_POP_RD:
            begin
                count_next = count_dec;
                state_next = S_POP_SYM;
            end
            S_POP_SYM:
            begin
                state_next = S_POP_OUT;
            end
            S_POP_OUT:
            begin
                if (slot_free)
                begin
                    oval_next  = 1'b1;
                    ochar_next = alph_rdata;
                    olast_next = (count_reg == '0);
                    state_next = (count_reg == '0) ? S_IDLE : S_POP_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            oval_reg  <= oval_next;
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        neg_reg   <= neg_next;
        mag_reg   <= mag_next;
        scan_reg  <= scan_next;
        radix_reg <= radix_next;
        seen_reg  <= seen_next;
        ochar_reg <= ochar_next;
        olast_reg <= olast_next;
    end

    // ports
    assign request.ready   = (state_reg == S_IDLE);
    assign result.valid    = oval_reg;
    assign result.out_char = ochar_reg;
    assign result.run_last = olast_reg;

endmodule

/* sim/sdre_char_checker.sv */
// request monitor, character predictor and result comparison for the digit encoder
`timescale 1ns / 100ps

module sdre_char_checker
    import sdre_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    sdre_req_if  request,
    sdre_res_if  result,
    output int   fail_count,
    output int   pending,
    output int   convert_count,
    output int   reject_count,
    output int   char_count
);

    localparam int MaxReports = 40;

    typedef struct packed {
        logic [CharW-1:0] ch;
        logic             last;
    } char_rec_t;

    // own copy of the alphabet table and the characters still owed
    logic [CharW-1:0] symbol_table [MAX_RADIX];
    char_rec_t        expected_chars [$];

    // one line per mismatch, printing capped, counting not
    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= MaxReports)
            $display("%0t ns: %s", $time, what);
    endtask

    // length of a usable alphabet, or zero when the table fails the check
    function automatic int alphabet_radix();
        int               len;
        int               i;
        int               j;
        logic [CharW-1:0] c;
        len = 0;
        while (len < MAX_RADIX && symbol_table[len] != CHAR_NUL)
            len++;
        if (len < 2)
            return 0;
        for (i = 0; i < len; i++)
        begin
            c = symbol_table[i];
            if (c < CHAR_LO || c > CHAR_HI || c == CHAR_PLUS || c == CHAR_MINUS)
                return 0;
            for (j = i + 1; j < len; j++)
                if (symbol_table[j] == c)
                    return 0;
        end
        return len;
    endfunction

    // queue the sign and digit characters that one convert request owes
    function automatic void render_value(input logic [ValueW-1:0] raw);
        int                radix;
        logic [ValueW-1:0] divisor;
        logic [ValueW-1:0] mag;
        logic [DigitW-1:0] digits [$];
        logic [DigitW-1:0] d;
        convert_count++;
        radix = alphabet_radix();
        if (radix == 0)
        begin
            reject_count++;
            return;
        end
        divisor = ValueW'(radix);
        if (raw[ValueW-1])
        begin
            mag = ~raw + 1'b1;
            expected_chars.push_back('{ch: CHAR_MINUS, last: 1'b0});
        end
        else
            mag = raw;
        // least significant digit first, emitted in reverse
        do
        begin
            digits.push_back(DigitW'(mag % divisor));
            mag = mag / divisor;
        end
        while (mag != 0);
        while (digits.size() > 0)
        begin
            d = digits.pop_back();
            expected_chars.push_back('{ch: symbol_table[d], last: digits.size() == 0});
        end
    endfunction

    // compare each accepted character, then predict from each accepted request
    always @(posedge clk or negedge rst_n)
    begin
        char_rec_t want;
        if (!rst_n)
        begin
            foreach (symbol_table[k])
                symbol_table[k] = CHAR_NUL;
            expected_chars.delete();
            fail_count    = 0;
            convert_count = 0;
            reject_count  = 0;
            char_count    = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (expected_chars.size() == 0)
                    report_mismatch($sformatf("character 0x%02h last=%0b with none owed",
                                              result.out_char, result.run_last));
                else
                begin
                    want = expected_chars.pop_front();
                    char_count++;
                    if (result.out_char !== want.ch)
                        report_mismatch($sformatf("out_char 0x%02h, owed 0x%02h",
                                                  result.out_char, want.ch));
                    if (result.run_last !== want.last)
                        report_mismatch($sformatf("run_last %0b, owed %0b on char 0x%02h",
                                                  result.run_last, want.last, want.ch));
                end
            end
            if (request.valid && request.ready)
            begin
                if (request.req_type == REQ_LOAD)
                    symbol_table[request.symbol_index] = request.symbol_byte;
                else
                    render_value(request.number_value);
            end
        end
        pending = expected_chars.size();
    end

endmodule

/* sim/tb_top.sv */
// stimulus, handshake pacing and verdict for the signed radix digit encoder
`timescale 1ns / 100ps

module tb_top
    import sdre_pkg::*;
();

    localparam int PhaseItems  = 40;
    localparam int DrainCycles = 1500;
    localparam int CycleLimit  = 2000000;

    typedef enum int {
        FLAW_NONE,
        FLAW_REPEAT,
        FLAW_LOW_BYTE,
        FLAW_HIGH_BYTE,
        FLAW_PLUS,
        FLAW_MINUS,
        FLAW_SHORT
    } flaw_t;

    logic clk;
    logic rst_n;
    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    int   items_sent    = 0;
    int   cycle_count   = 0;
    int   fail_count;
    int   pending;
    int   convert_count;
    int   reject_count;
    int   char_count;

    sdre_req_if req_ch ();
    sdre_res_if res_ch ();

    signed_radix_digit_encoder_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_ch),
        .result  (res_ch)
    );

    sdre_char_checker char_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .request       (req_ch),
        .result        (res_ch),
        .fail_count    (fail_count),
        .pending       (pending),
        .convert_count (convert_count),
        .reject_count  (reject_count),
        .char_count    (char_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // sink stalls at the current phase rate
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            res_ch.ready <= rst_n && ($urandom_range(99, 0) >= stall_pct);
        end
    end

    // run limit
    initial
    begin
        while (cycle_count <= CycleLimit)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("signed_radix_digit_encoder_unit: mismatch");
        $finish;
    end

    // one request, with a random gap in front, held until taken
    task automatic send_request(input logic kind, input logic [AlphAddrW-1:0] idx,
                                input logic [CharW-1:0] sym,
                                input logic [ValueW-1:0] value);
        if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99, 0) < send_idle_pct);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= kind;
        req_ch.symbol_index <= idx;
        req_ch.symbol_byte  <= sym;
        req_ch.number_value <= value;
        do
            @(posedge clk);
        while (!req_ch.ready);
        items_sent++;
    endtask

    // load request, convert field filled with noise
    task automatic load_symbol(input int idx, input int sym);
        send_request(REQ_LOAD, AlphAddrW'(idx), CharW'(sym), $urandom());
    endtask

    // convert request, symbol fields filled with noise
    task automatic convert_value(input logic [ValueW-1:0] value);
        send_request(REQ_CONVERT, AlphAddrW'($urandom()), CharW'($urandom()), value);
    endtask

    // distinct printable symbols, optionally spoilt, then the terminator
    task automatic load_alphabet(input int radix, input flaw_t flaw);
        logic [CharW-1:0] pool [$];
        logic [CharW-1:0] tmp;
        int               k;
        int               j;
        int               stop_at;
        for (k = CHAR_LO; k <= CHAR_HI; k++)
            if (k != CHAR_PLUS && k != CHAR_MINUS)
                pool.push_back(CharW'(k));
        for (k = 0; k < radix; k++)
        begin
            j = $urandom_range(pool.size() - 1, k);
            tmp = pool[k];
            pool[k] = pool[j];
            pool[j] = tmp;
        end
        k = $urandom_range(radix - 1, 0);
        stop_at = radix;
        case (flaw)
            FLAW_REPEAT:    pool[k] = pool[(k + 1 + $urandom_range(radix - 2, 0)) % radix];
            FLAW_LOW_BYTE:  pool[k] = CharW'($urandom_range(31, 1));
            FLAW_HIGH_BYTE: pool[k] = CharW'($urandom_range(255, 127));
            FLAW_PLUS:      pool[k] = CHAR_PLUS;
            FLAW_MINUS:     pool[k] = CHAR_MINUS;
            FLAW_SHORT:     stop_at = $urandom_range(1, 0);
            default:        ;
        endcase
        for (k = 0; k < radix; k++)
            load_symbol(k, pool[k]);
        if (stop_at < MAX_RADIX)
            load_symbol(stop_at, CHAR_NUL);
    endtask

    // radix mostly small, with both ends of the range now and then
    function automatic int pick_radix();
        case ($urandom_range(9, 0))
            0:       return MAX_RADIX;
            1:       return 2;
            2, 3:    return $urandom_range(MAX_RADIX - 1, 17);
            default: return $urandom_range(16, 3);
        endcase
    endfunction

    // value mix: extremes, small of either sign, full range
    function automatic logic [ValueW-1:0] pick_value();
        case ($urandom_range(5, 0))
            0:
            begin
                case ($urandom_range(3, 0))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            1:       return ValueW'($urandom_range(200, 0));
            2:       return -ValueW'($urandom_range(200, 1));
            default: return $urandom();
        endcase
    endfunction

    // stimulus and verdict
    initial
    begin
        int roll;
        int phase;
        int phase_end;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = REQ_LOAD;
        req_ch.symbol_index = '0;
        req_ch.symbol_byte  = CHAR_NUL;
        req_ch.number_value = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, then a single symbol: both rejected
        convert_value(32'd5);
        load_symbol(0, "0");
        convert_value(32'd7);
        // binary alphabet: most negative, zero, most positive, minus one
        load_symbol(1, "1");
        convert_value(32'h8000_0000);
        convert_value(32'h0000_0000);
        convert_value(32'h7FFF_FFFF);
        convert_value(32'hFFFF_FFFF);
        // third symbol spoilt in each way the check looks for
        load_symbol(2, CHAR_MINUS);
        convert_value(32'd1);
        load_symbol(2, CHAR_PLUS);
        convert_value(32'd2);
        load_symbol(2, 31);
        convert_value(32'd3);
        load_symbol(2, 127);
        convert_value(32'd4);
        load_symbol(2, 255);
        convert_value(32'd5);
        load_symbol(2, "0");
        convert_value(32'd6);
        // range edges as symbols, radix four
        load_symbol(2, CHAR_HI);
        load_symbol(3, CHAR_LO);
        convert_value(-32'sd123456);
        load_symbol(63, 255);
        load_symbol(4, CHAR_NUL);

        // random part in four pacing phases
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct    <= 0;
                end
                1:
                begin
                    send_idle_pct = 62;
                    stall_pct    <= 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct    <= 62;
                end
                default:
                begin
                    send_idle_pct = 37;
                    stall_pct    <= 37;
                end
            endcase
            phase_end = items_sent + PhaseItems;
            while (items_sent < phase_end)
            begin
                roll = $urandom_range(99, 0);
                if (roll < 70)
                begin
                    load_alphabet(pick_radix(), FLAW_NONE);
                    repeat ($urandom_range(6, 2))
                        convert_value(pick_value());
                end
                else if (roll < 88)
                begin
                    load_alphabet($urandom_range(12, 2),
                                  flaw_t'($urandom_range(FLAW_SHORT, FLAW_REPEAT)));
                    repeat ($urandom_range(2, 1))
                        convert_value(pick_value());
                end
                else
                begin
                    repeat ($urandom_range(6, 1))
                        load_symbol($urandom_range(63, 0), $urandom_range(255, 0));
                    convert_value(pick_value());
                end
            end
        end

        // drain owed characters, then watch for strays
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DrainCycles) @(posedge clk);

        $display("covered %0d requests: %0d conversions, %0d on a rejected alphabet",
                 items_sent, convert_count, reject_count);
        $display("%0d characters compared under free, gapped, stalled and mixed pacing",
                 char_count);
        if (fail_count == 0)
            $display("signed_radix_digit_encoder_unit: match");
        else
            $display("signed_radix_digit_encoder_unit: mismatch");
        $finish;
    end

endmodule
